@@ sv/ffa_pkg.sv @@
// ffa_pkg: shared types and codes for the first-fit segment allocator.
// Used by the allocator core; depends on nothing.
package ffa_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVER      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  localparam logic [1:0] REG_POOL_BASE    = 2'd0;
  localparam logic [1:0] REG_INITIAL_SIZE = 2'd1;
  localparam logic [1:0] REG_MAX_TOTAL    = 2'd2;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,     // rebuild table: slot zero only
    S_IDLE,
    S_READ,      // memory read of current slot issued
    S_EXAM,      // examine current slot data
    S_NREAD,     // read successor for merge
    S_NEXAM,
    S_WRITE,     // final writes
    S_DONE
  } state_t;

endpackage

@@ sv/first_fit_aligned_segment_allocator_core.sv @@
// first_fit_aligned_segment_allocator_core: top level of the segment allocator.
// Depends on ffa_pkg and ffa_free_slots.
//
// Usage: an item on the in channel (cmd, req_size, grow_base, release_addr)
// is accepted when in_valid and in_ready are high. cmd 0 acquires req_size
// bytes first-fit (power-of-two sizes aligned up to the size), cmd 1 releases
// a previously handed-out address and merges with free neighbors. Exactly
// one result (block_addr, status) leaves on the out channel per item.
// The segment list lives in a memory with a registered read port; the walk
// visits each segment in a read state and then an examine state.
// One item is handled at a time. The result is held in an output register;
// while the receiver stalls, in_ready stays low.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken when
// idle; writing pool_base or initial_size rebuilds the table. Reset
// rebuilds the table with the register reset values.
module first_fit_aligned_segment_allocator_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] req_size,
  input  logic [31:0] grow_base,
  input  logic [31:0] release_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] block_addr,
  output logic [2:0]  status
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [63:0] AMASK =
    (ADDR_WIDTH >= 64) ? '1 : ((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [31:0] AMASK32 = AMASK[31:0];

  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] aligned;
    logic [31:0] len;
    logic        used;
    logic [IW-1:0] link;
  } seg_t;

  // segment memory, one write port, one registered read port
  seg_t mem [MAX_SEGMENTS];
  seg_t rd;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  seg_t          wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  // registers
  logic [31:0] pool_base, initial_size, max_total, total_bytes;
  ffa_pkg::state_t state, state_next;
  logic        op;
  logic [31:0] size, grow, raddr;
  logic [IW-1:0] cur, prev, last;
  logic        has_prev;
  seg_t        cs, ps;           // current and previous segment copies
  logic [IW:0] steps;
  logic [31:0] res_addr;
  logic [2:0]  res_status;
  // pending write plan
  logic [1:0]  wphase;

  logic        fs_found;
  logic [IW-1:0] fs_idx;
  logic        fs_set, fs_drop;
  logic [IW-1:0] fs_set_idx, fs_drop_idx;
  logic        rebuild;

  ffa_free_slots #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_slots (
    .clk, .rst, .clear(rebuild),
    .set_en(fs_set), .set_idx(fs_set_idx),
    .drop_en(fs_drop), .drop_idx(fs_drop_idx),
    .found(fs_found), .free_idx(fs_idx)
  );

  assign cfg_ready = (state == ffa_pkg::S_IDLE);
  assign in_ready  = (state == ffa_pkg::S_IDLE) && !cfg_valid;
  assign out_valid = (state == ffa_pkg::S_DONE);
  assign block_addr = res_addr;
  assign status     = res_status;
  assign rebuild = (state == ffa_pkg::S_CLEAR);

  // examine-stage arithmetic on the current segment
  logic        pow2;
  logic [32:0] pad, need, alup;
  logic        fit_eq, fit_gt;
  logic [32:0] grown;
  logic        touch_pc, touch_cn;
  logic [32:0] msum;
  logic [31:0] msat;

  always_comb begin
    pow2 = (size != 32'd0) && ((size & (size - 32'd1)) == 32'd0);
    alup = ({1'b0, rd.raw} + {1'b0, size} - 33'd1) & ~({1'b0, size} - 33'd1);
    pad  = pow2 ? (alup - {1'b0, rd.raw}) : 33'd0;
    need = {1'b0, size} + pad;
    fit_eq = ({1'b0, rd.len} == need);
    fit_gt = ({1'b0, rd.len} > need);
    grown = {1'b0, total_bytes} + {1'b0, size};
    touch_pc = ({1'b0, ps.raw} + {1'b0, ps.len}) == {1'b0, rd.raw};
    touch_cn = ({1'b0, cs.raw} + {1'b0, cs.len}) == {1'b0, rd.raw};
    msum = {1'b0, cs.len} + {1'b0, rd.len};
    msat = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffa_pkg::S_CLEAR: state_next = ffa_pkg::S_IDLE;
      ffa_pkg::S_IDLE: begin
        if (cfg_valid && (cfg_index == ffa_pkg::REG_POOL_BASE ||
                          cfg_index == ffa_pkg::REG_INITIAL_SIZE))
          state_next = ffa_pkg::S_CLEAR;
        else if (in_valid && in_ready) state_next = ffa_pkg::S_READ;
      end
      ffa_pkg::S_READ:  state_next = ffa_pkg::S_EXAM;
      ffa_pkg::S_EXAM:  state_next = ffa_pkg::S_READ;   // refined in clocked block
      ffa_pkg::S_NREAD: state_next = ffa_pkg::S_NEXAM;
      ffa_pkg::S_NEXAM: state_next = ffa_pkg::S_WRITE;
      ffa_pkg::S_WRITE: state_next = ffa_pkg::S_DONE;
      ffa_pkg::S_DONE:  if (out_ready) state_next = ffa_pkg::S_IDLE;
      default:          state_next = ffa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control; the walk decisions live here
  always_ff @(posedge clk) begin
    wr_en   <= 1'b0;
    fs_set  <= 1'b0;
    fs_drop <= 1'b0;
    if (rst) begin
      state <= ffa_pkg::S_CLEAR;
      pool_base <= 32'd0;
      initial_size <= 32'd4096;
      max_total <= 32'd0;
      total_bytes <= 32'd4096;
    end else begin
      state <= state_next;
      unique case (state)
        ffa_pkg::S_CLEAR: begin
          wr_en   <= 1'b1;
          wr_addr <= '0;
          wr_data <= '{raw: pool_base & AMASK32, aligned: pool_base & AMASK32,
                       len: initial_size, used: 1'b0, link: '0};
          total_bytes <= initial_size;
        end
        ffa_pkg::S_IDLE: begin
          if (cfg_valid) begin
            priority case (cfg_index)
              ffa_pkg::REG_POOL_BASE:    pool_base <= cfg_data;
              ffa_pkg::REG_INITIAL_SIZE: initial_size <= cfg_data;
              ffa_pkg::REG_MAX_TOTAL:    max_total <= cfg_data;
              default: ;
            endcase
          end else if (in_valid) begin
            op <= cmd; size <= req_size; grow <= grow_base; raddr <= release_addr;
            cur <= '0; last <= '0; has_prev <= 1'b0; steps <= '0;
            rd_addr <= '0;
            res_addr <= 32'd0;
            if (cmd == ffa_pkg::CMD_ACQUIRE && req_size == 32'd0) begin
              res_status <= ffa_pkg::ST_ZERO;
              state <= ffa_pkg::S_DONE;
            end
          end
        end
        ffa_pkg::S_READ: ;
        ffa_pkg::S_EXAM: begin
          cs <= rd;
          steps <= steps + 1'b1;
          last <= cur;
          if (op == ffa_pkg::CMD_ACQUIRE) begin
            if (!rd.used && fit_eq) begin
              wr_en <= 1'b1; wr_addr <= cur;
              wr_data <= '{raw: rd.raw, aligned: rd.raw + pad[31:0] & AMASK32,
                           len: rd.len, used: 1'b1, link: rd.link};
              res_addr <= (rd.raw + pad[31:0]) & AMASK32;
              res_status <= ffa_pkg::ST_OK;
              state <= ffa_pkg::S_DONE;
            end else if (!rd.used && fit_gt) begin
              if (!fs_found) begin
                res_status <= ffa_pkg::ST_FULL;
                state <= ffa_pkg::S_DONE;
              end else begin
                // new free tail first, then current in S_WRITE
                wr_en <= 1'b1; wr_addr <= fs_idx;
                wr_data <= '{raw: (rd.raw + need[31:0]) & AMASK32,
                             aligned: (rd.raw + need[31:0]) & AMASK32,
                             len: rd.len - need[31:0], used: 1'b0,
                             link: (rd.link == cur) ? fs_idx : rd.link};
                fs_set <= 1'b1; fs_set_idx <= fs_idx;
                cs <= '{raw: rd.raw, aligned: (rd.raw + pad[31:0]) & AMASK32,
                        len: need[31:0], used: 1'b1, link: fs_idx};
                res_addr <= (rd.raw + pad[31:0]) & AMASK32;
                res_status <= ffa_pkg::ST_OK;
                wphase <= 2'd0;
                state <= ffa_pkg::S_WRITE;
              end
            end else if (rd.link != cur && steps != (IW+1)'(MAX_SEGMENTS - 1)) begin
              cur <= rd.link; rd_addr <= rd.link;
              state <= ffa_pkg::S_READ;
            end else if (max_total != 32'd0 && grown > {1'b0, max_total}) begin
              res_status <= ffa_pkg::ST_OVER;
              state <= ffa_pkg::S_DONE;
            end else if (!fs_found) begin
              res_status <= ffa_pkg::ST_FULL;
              state <= ffa_pkg::S_DONE;
            end else begin
              wr_en <= 1'b1; wr_addr <= fs_idx;
              wr_data <= '{raw: grow & AMASK32, aligned: grow & AMASK32,
                           len: size, used: 1'b1, link: fs_idx};
              fs_set <= 1'b1; fs_set_idx <= fs_idx;
              cs <= rd; cs.link <= fs_idx;
              cur <= cur;
              total_bytes <= grown[31:0];
              res_addr <= grow & AMASK32;
              res_status <= ffa_pkg::ST_OK;
              wphase <= 2'd0;
              state <= ffa_pkg::S_WRITE;
            end
          end else begin
            if (rd.used && rd.aligned == raddr) begin
              res_status <= ffa_pkg::ST_OK;
              if (has_prev && !ps.used && touch_pc) begin
                // absorb current into previous
                cs <= ps;
                cs.len <= ({1'b0, ps.len} + {1'b0, rd.len}) > 33'h0FFFF_FFFF ?
                          32'hFFFF_FFFF : ps.len + rd.len;
                cs.link <= (rd.link == cur) ? prev : rd.link;
                cs.used <= 1'b0;
                fs_drop <= 1'b1; fs_drop_idx <= cur;
                cur <= prev;
                if (rd.link != cur) begin
                  rd_addr <= rd.link; state <= ffa_pkg::S_NREAD;
                end else begin
                  wphase <= 2'd1; state <= ffa_pkg::S_WRITE;
                end
              end else begin
                cs.used <= 1'b0;
                if (rd.link != cur) begin
                  rd_addr <= rd.link; state <= ffa_pkg::S_NREAD;
                end else begin
                  wphase <= 2'd1; state <= ffa_pkg::S_WRITE;
                end
              end
            end else if (rd.link != cur && steps != (IW+1)'(MAX_SEGMENTS - 1)) begin
              ps <= rd; prev <= cur; has_prev <= 1'b1;
              cur <= rd.link; rd_addr <= rd.link;
              state <= ffa_pkg::S_READ;
            end else begin
              res_status <= ffa_pkg::ST_NOT_FOUND;
              state <= ffa_pkg::S_DONE;
            end
          end
        end
        ffa_pkg::S_NREAD: ;
        ffa_pkg::S_NEXAM: begin
          // cs holds the freed (possibly merged) segment; rd is its successor
          if (!rd.used && touch_cn) begin
            cs.len  <= msat;
            cs.link <= (rd.link == cs.link) ? cur : rd.link;
            fs_drop <= 1'b1; fs_drop_idx <= cs.link;
          end
          wphase <= 2'd1;
        end
        ffa_pkg::S_WRITE: begin
          wr_en <= 1'b1;
          if (op == ffa_pkg::CMD_ACQUIRE && cs.link != cur && wphase == 2'd0 &&
              res_addr == (grow & AMASK32) && !cs.used) begin
            // growth: relink last segment to the new slot
            wr_addr <= last; wr_data <= cs;
          end else begin
            wr_addr <= cur; wr_data <= cs;
          end
        end
        ffa_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::S_DONE && !out_ready) |=> (state == ffa_pkg::S_DONE && $stable(res_status)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_status <= ffa_pkg::ST_ZERO))
    else $error("bad status code");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status != ffa_pkg::ST_OK) |-> (res_addr == 32'd0))
    else $error("address on failed item");
endmodule

@@ sv/ffa_free_slots.sv @@
// ffa_free_slots: slot occupancy flags and lowest-free-slot search.
// Uses no items of ffa_pkg; depends on nothing.
module ffa_free_slots #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            set_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] set_idx,
  input  logic                            drop_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] drop_idx,
  output logic                            found,
  output logic [$clog2(MAX_SEGMENTS)-1:0] free_idx
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  logic [MAX_SEGMENTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      valid[0] <= 1'b1;
    end else begin
      if (set_en) valid[set_idx] <= 1'b1;
      if (drop_en) valid[drop_idx] <= 1'b0;
    end
  end

  // priority encoder, lowest free slot above zero
  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 1; i--) begin
      if (!valid[i]) begin
        found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end
endmodule
